[hdl/rrts_pkg.sv]
// ----------------------------------------------------------------------------
// Round-robin thread scheduler package
// Shared constants, codes and controller/datapath bundles.
// ----------------------------------------------------------------------------
package rrts_pkg;

   localparam int MAX_THREADS = 16;
   localparam int SLOT_BITS   = $clog2(MAX_THREADS);
   localparam int TID_BITS    = 16;
   localparam int TICK_BITS   = 8;
   localparam logic [TICK_BITS-1:0] SLICE_RESET = TICK_BITS'(5);
   localparam logic [TICK_BITS-1:0] TICK_MAX    = {TICK_BITS{1'b1}};

   typedef enum logic [2:0] {
      OP_CREATE  = 3'd0,
      OP_DELETE  = 3'd1,
      OP_YIELD   = 3'd2,
      OP_BLOCK   = 3'd3,
      OP_UNBLOCK = 3'd4,
      OP_TICK    = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_REFUSED   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_LINK1,
      S_LINK2,
      S_FIND,
      S_UNLINK,
      S_RUNSET,
      S_SR_ADV,
      S_SR_CHK,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic       req_ready;
      logic       ptr_adv;
      logic       ptr_snext;
      logic       sel_latch;
      logic       cr_alloc;
      logic       cr_solo;
      logic       link1;
      logic       link2;
      logic       ready_set;
      logic       ready_clr;
      logic       unlink;
      logic       run_set;
      logic       tick_inc;
      logic       tick_clr;
      logic       status_we;
      status_type status_code;
      logic       rsp_load;
   } rrts_cmd_type;

   typedef struct packed {
      logic       accepted;
      opcode_type op;
      logic       run_valid;
      logic       free_found;
      logic       tick_expire;
      logic       ptr_is_run;
      logic       ptr_match;
      logic       ptr_next_is_run;
      logic       ptr_solo;
      logic       sel_is_run;
      logic       srch_hit;
   } rrts_stat_type;

endpackage

[hdl/rrts_req_if.sv]
// ----------------------------------------------------------------------------
// Scheduler command channel
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
interface rrts_req_if;
   logic                          valid;
   logic                          ready;
   logic [2:0]                    opcode;
   logic [rrts_pkg::TID_BITS-1:0] thread_id;

   modport source (output valid, output opcode, output thread_id, input ready);
   modport sink   (input valid, input opcode, input thread_id, output ready);
endinterface

[hdl/rrts_rsp_if.sv]
// ----------------------------------------------------------------------------
// Scheduler response channel
// Valid/ready channel carrying one response word.
// ----------------------------------------------------------------------------
interface rrts_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic [rrts_pkg::TID_BITS-1:0] new_tid;
   logic                          running_valid;
   logic [rrts_pkg::TID_BITS-1:0] running_tid;
   logic                          switched;

   modport source (output valid, output status, output new_tid, output running_valid,
                   output running_tid, output switched, input ready);
   modport sink   (input valid, input status, input new_tid, input running_valid,
                   input running_tid, input switched, output ready);
endinterface

[hdl/rrts_ctrl.sv]
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences each command through the slot table walks of the datapath.
// ----------------------------------------------------------------------------
module rrts_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  rrts_pkg::rrts_stat_type stat,
   output rrts_pkg::rrts_cmd_type  cmd
);
   import rrts_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.status_code = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            cmd.req_ready = 1'b1;
            if (stat.accepted) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_FINISH;
            unique case (stat.op) inside
               OP_CREATE: begin
                  if (!stat.free_found) begin
                     cmd.status_we   = 1'b1;
                     cmd.status_code = ST_FULL;
                  end else begin
                     cmd.cr_alloc = 1'b1;
                     if (stat.run_valid) begin
                        state_in = S_LINK1;
                     end else begin
                        cmd.cr_solo = 1'b1;
                     end
                  end
               end
               OP_DELETE, OP_BLOCK, OP_UNBLOCK: begin
                  if (!stat.run_valid) begin
                     cmd.status_we   = 1'b1;
                     cmd.status_code = ST_NOT_FOUND;
                  end else begin
                     state_in = S_FIND;
                  end
               end
               OP_YIELD: begin
                  if (stat.run_valid) begin
                     state_in = S_SR_ADV;
                  end
               end
               OP_TICK: begin
                  if (stat.tick_expire) begin
                     cmd.tick_clr = 1'b1;
                     state_in     = S_SR_ADV;
                  end else begin
                     cmd.tick_inc = 1'b1;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_LINK1: begin
            cmd.link1 = 1'b1;
            state_in  = S_LINK2;
         end
         S_LINK2: begin
            cmd.link2 = 1'b1;
            state_in  = S_FINISH;
         end
         S_FIND: begin
            if (stat.ptr_match) begin
               state_in = S_FINISH;
               unique case (stat.op) inside
                  OP_DELETE: begin
                     if (stat.ptr_is_run && stat.ptr_solo) begin
                        cmd.status_we   = 1'b1;
                        cmd.status_code = ST_REFUSED;
                     end else begin
                        cmd.sel_latch = 1'b1;
                        state_in      = S_UNLINK;
                     end
                  end
                  OP_BLOCK: begin
                     cmd.ready_clr = 1'b1;
                     if (stat.ptr_is_run) begin
                        state_in = S_SR_ADV;
                     end
                  end
                  default: begin
                     cmd.ready_set = 1'b1;
                  end
               endcase
            end else if (stat.ptr_next_is_run) begin
               cmd.status_we   = 1'b1;
               cmd.status_code = ST_NOT_FOUND;
               state_in        = S_FINISH;
            end else begin
               cmd.ptr_adv = 1'b1;
            end
         end
         S_UNLINK: begin
            cmd.unlink    = 1'b1;
            cmd.ptr_snext = 1'b1;
            state_in      = stat.sel_is_run ? S_RUNSET : S_FINISH;
         end
         S_RUNSET: begin
            cmd.run_set = 1'b1;
            state_in    = S_FINISH;
         end
         S_SR_ADV: begin
            cmd.ptr_adv = 1'b1;
            state_in    = S_SR_CHK;
         end
         S_SR_CHK: begin
            if (stat.srch_hit) begin
               cmd.run_set = 1'b1;
               state_in    = S_FINISH;
            end else if (stat.ptr_is_run) begin
               state_in = S_FINISH;
            end else begin
               cmd.ptr_adv = 1'b1;
            end
         end
         S_FINISH: begin
            cmd.rsp_load = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[hdl/rrts_dp.sv]
// ----------------------------------------------------------------------------
// Scheduler datapath
// Slot table, ring links, running thread, counters and response register.
// ----------------------------------------------------------------------------
module rrts_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [rrts_pkg::TICK_BITS-1:0] csr_wr_data,
   rrts_req_if.sink                       req_chan,
   rrts_rsp_if.source                     rsp_chan,
   input  rrts_pkg::rrts_cmd_type         cmd,
   output rrts_pkg::rrts_stat_type        stat
);
   import rrts_pkg::*;

   logic [MAX_THREADS-1:0] used_ff;
   logic [TID_BITS-1:0]    tid_mem  [MAX_THREADS];
   logic                   rdy_mem  [MAX_THREADS];
   logic [SLOT_BITS-1:0]   next_mem [MAX_THREADS];
   logic [SLOT_BITS-1:0]   prev_mem [MAX_THREADS];

   logic [SLOT_BITS-1:0]   run_slot_ff;
   logic                   run_valid_ff;
   logic [TID_BITS-1:0]    run_tid_ff;
   logic [TID_BITS-1:0]    tid_cnt_ff;
   logic [TICK_BITS-1:0]   tick_ff;
   logic [TICK_BITS-1:0]   slice_ff;

   opcode_type             op_ff;
   logic [TID_BITS-1:0]    target_ff;
   logic [SLOT_BITS-1:0]   ptr_ff;
   logic [SLOT_BITS-1:0]   sel_slot_ff, sel_next_ff, sel_prev_ff;
   logic                   sel_is_run_ff;
   status_type             status_ff;
   logic [TID_BITS-1:0]    new_tid_ff;
   logic                   switched_ff;

   logic                   rsp_valid_ff;
   logic                   out_free;
   logic                   accepted;
   logic [SLOT_BITS-1:0]   free_slot;
   logic                   free_found;
   logic [TICK_BITS-1:0]   tick_in;
   logic [SLOT_BITS-1:0]   ptr_next;
   logic                   ptr_is_run;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = cmd.req_ready && out_free;
   assign accepted       = req_chan.valid && req_chan.ready;
   assign ptr_next       = next_mem[ptr_ff];
   assign ptr_is_run     = (ptr_ff == run_slot_ff);
   assign tick_in        = (tick_ff == TICK_MAX) ? TICK_MAX : tick_ff + TICK_BITS'(1);

   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = MAX_THREADS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_slot  = SLOT_BITS'(i);
         end
      end
   end

   always_comb begin
      stat                 = '0;
      stat.accepted        = accepted;
      stat.op              = op_ff;
      stat.run_valid       = run_valid_ff;
      stat.free_found      = free_found;
      stat.tick_expire     = run_valid_ff && !(tick_in < slice_ff);
      stat.ptr_is_run      = ptr_is_run;
      stat.ptr_match       = (tid_mem[ptr_ff] == target_ff);
      stat.ptr_next_is_run = (ptr_next == run_slot_ff);
      stat.ptr_solo        = (ptr_next == ptr_ff);
      stat.sel_is_run      = sel_is_run_ff;
      stat.srch_hit        = rdy_mem[ptr_ff] && (!ptr_is_run || (op_ff == OP_TICK));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         run_slot_ff  <= '0;
         run_valid_ff <= 1'b0;
         tid_cnt_ff   <= '0;
         tick_ff      <= '0;
         slice_ff     <= SLICE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            slice_ff <= csr_wr_data;
         end
         if (cmd.tick_inc) begin
            tick_ff <= tick_in;
         end
         if (cmd.tick_clr) begin
            tick_ff <= '0;
         end
         if (cmd.cr_alloc) begin
            used_ff[free_slot] <= 1'b1;
            tid_cnt_ff         <= tid_cnt_ff + TID_BITS'(1);
         end
         if (cmd.cr_solo) begin
            run_slot_ff  <= free_slot;
            run_valid_ff <= 1'b1;
         end
         if (cmd.unlink) begin
            used_ff[sel_slot_ff] <= 1'b0;
         end
         if (cmd.run_set) begin
            run_slot_ff <= ptr_ff;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accepted) begin
         op_ff       <= opcode_type'(req_chan.opcode);
         target_ff   <= req_chan.thread_id;
         ptr_ff      <= run_slot_ff;
         status_ff   <= ST_OK;
         new_tid_ff  <= '0;
         switched_ff <= 1'b0;
      end
      if (cmd.ptr_adv) begin
         ptr_ff <= ptr_next;
      end
      if (cmd.ptr_snext) begin
         ptr_ff <= sel_next_ff;
      end
      if (cmd.status_we) begin
         status_ff <= cmd.status_code;
      end
      if (cmd.cr_alloc) begin
         tid_mem[free_slot] <= tid_cnt_ff;
         rdy_mem[free_slot] <= 1'b1;
         new_tid_ff         <= tid_cnt_ff;
         sel_slot_ff        <= free_slot;
         sel_next_ff        <= ptr_next;
      end
      if (cmd.cr_solo) begin
         next_mem[free_slot] <= free_slot;
         prev_mem[free_slot] <= free_slot;
         run_tid_ff          <= tid_cnt_ff;
         switched_ff         <= 1'b1;
      end
      if (cmd.link1) begin
         next_mem[sel_slot_ff] <= sel_next_ff;
         prev_mem[sel_slot_ff] <= run_slot_ff;
      end
      if (cmd.link2) begin
         prev_mem[sel_next_ff] <= sel_slot_ff;
         next_mem[run_slot_ff] <= sel_slot_ff;
      end
      if (cmd.sel_latch) begin
         sel_slot_ff   <= ptr_ff;
         sel_next_ff   <= ptr_next;
         sel_prev_ff   <= prev_mem[ptr_ff];
         sel_is_run_ff <= ptr_is_run;
      end
      if (cmd.ready_set) begin
         rdy_mem[ptr_ff] <= 1'b1;
      end
      if (cmd.ready_clr) begin
         rdy_mem[ptr_ff] <= 1'b0;
      end
      if (cmd.unlink) begin
         next_mem[sel_prev_ff] <= sel_next_ff;
         prev_mem[sel_next_ff] <= sel_prev_ff;
      end
      if (cmd.run_set) begin
         run_tid_ff  <= tid_mem[ptr_ff];
         switched_ff <= 1'b1;
      end
      if (cmd.rsp_load) begin
         rsp_chan.status        <= status_ff;
         rsp_chan.new_tid       <= new_tid_ff;
         rsp_chan.running_valid <= run_valid_ff;
         rsp_chan.running_tid   <= run_valid_ff ? run_tid_ff : '0;
         rsp_chan.switched      <= switched_ff;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;

endmodule

[hdl/round_robin_thread_scheduler.sv]
// ----------------------------------------------------------------------------
// Round-robin thread scheduler
// Top level: command and response channels, timeslice register.
// ----------------------------------------------------------------------------
// Commands are handled one at a time and each gives one response word. The
// id search and the ready-thread search each walk the ring one slot per
// cycle through the single read port of the slot table, and no command
// makes both walks long. The next command is taken in the cycle after the
// response is loaded into the output register, once that register is empty
// or is read in that cycle.
module round_robin_thread_scheduler (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [rrts_pkg::TICK_BITS-1:0] csr_wr_data,
   rrts_req_if.sink                       req_chan,
   rrts_rsp_if.source                     rsp_chan
);
   import rrts_pkg::*;

   rrts_cmd_type  cmd;
   rrts_stat_type stat;

   rrts_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   rrts_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule
